// ----- rtl/rcfd_pkg.sv -----
// shared types and constants for the remote-control frame decoder
package rcfd_pkg;

	// frame geometry
	localparam int unsigned FRAME_BYTES = 18;
	localparam int unsigned CNT_W       = $clog2(FRAME_BYTES + 1);
	localparam int unsigned HDR_BYTES   = 6;
	localparam int unsigned HDR_IDX_W   = $clog2(HDR_BYTES);

	// field widths
	localparam int unsigned CH_W   = 11;
	localparam int unsigned SW_W   = 2;
	localparam int unsigned AGE_W  = 16;
	localparam int unsigned DZ_W   = 10;
	localparam int unsigned TMO_W  = 16;
	localparam int unsigned LIM_W  = 15;
	localparam int unsigned RNG_W  = 10;
	localparam int unsigned CTR_W  = 11;
	localparam int unsigned SPAN_W = 10;
	localparam int unsigned CUR_W  = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// divider sizing: |diff| * limit
	localparam int unsigned PROD_W  = CH_W + LIM_W;
	localparam int unsigned STEP_W  = $clog2(PROD_W);

	// register reset values
	localparam logic [DZ_W-1:0]   DZ_RST   = DZ_W'(20);
	localparam logic [TMO_W-1:0]  TMO_RST  = TMO_W'(100);
	localparam logic [LIM_W-1:0]  LIM_RST  = LIM_W'(16384);
	localparam logic [RNG_W-1:0]  RNG_RST  = RNG_W'(660);
	localparam logic [CTR_W-1:0]  CTR_RST  = CTR_W'(1024);
	localparam logic [SPAN_W-1:0] SPAN_RST = SPAN_W'(700);

	// event codes
	typedef enum logic [1:0] {
		MODE_BYTE = 2'd0,
		MODE_IDLE = 2'd1,
		MODE_TICK = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADZONE  = 3'd0,
		REG_TIMEOUT   = 3'd1,
		REG_LIMIT     = 3'd2,
		REG_RANGE     = 3'd3,
		REG_CENTER    = 3'd4,
		REG_SPAN      = 3'd5
	} reg_idx_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic mul_load;
		logic div_step;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_last;
	} status_t;

endpackage

// ----- rtl/rcfd_ctrl.sv -----
// controller state machine: sequences update, multiply, divide and result load
module rcfd_ctrl import rcfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MUL;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  if (status.div_last) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_MUL:  cmd.mul_load = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_OUT:  cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/rcfd_datapath.sv -----
// datapath: registers, frame store, unpack and check, age, current mapping divider
module rcfd_datapath import rcfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               status,
	input  logic [1:0]            mode,
	input  logic [7:0]            rx_byte,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic signed [CUR_W-1:0] current_cmd,
	output logic                  fresh,
	output logic                  frame_done,
	output logic                  frame_valid,
	output logic [CH_W-1:0]       ch_right_x,
	output logic [CH_W-1:0]       ch_right_y,
	output logic [CH_W-1:0]       ch_left_x,
	output logic [CH_W-1:0]       ch_left_y,
	output logic [SW_W-1:0]       switch_one,
	output logic [SW_W-1:0]       switch_two
);

	// configuration registers
	logic [DZ_W-1:0]   deadzone_q;
	logic [TMO_W-1:0]  timeout_q;
	logic [LIM_W-1:0]  limit_q;
	logic [RNG_W-1:0]  range_q;
	logic [CTR_W-1:0]  center_q;
	logic [SPAN_W-1:0] span_q;

	// decoder state
	logic [CNT_W-1:0] byte_cnt_q;
	logic [7:0]       fb_q [HDR_BYTES];
	logic [CH_W-1:0]  ch_q [4];
	logic [SW_W-1:0]  sw_q [2];
	logic [AGE_W-1:0] age_q;
	logic             done_q;
	logic             fvalid_q;

	// mapping datapath
	logic             neg_q;
	logic             dead_q;
	logic             zero_q;
	logic [PROD_W-1:0] work_q;
	logic [RNG_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;

	logic [CH_W-1:0]  unp_ch [4];
	logic [SW_W-1:0]  unp_sw [2];
	logic [3:0]       ch_ok;
	logic signed [CTR_W+1:0] lo_lim, hi_lim;
	logic signed [CTR_W:0]   diff;
	logic [CH_W-1:0]  abs_diff;
	logic [RNG_W:0]   trial;
	logic             trial_ge;
	logic [LIM_W-1:0] mag;
	logic             is_fresh;
	logic signed [CUR_W-1:0] cur;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q <= DZ_RST;
			timeout_q  <= TMO_RST;
			limit_q    <= LIM_RST;
			range_q    <= RNG_RST;
			center_q   <= CTR_RST;
			span_q     <= SPAN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEADZONE: deadzone_q <= cfg_data[DZ_W-1:0];
				REG_TIMEOUT:  timeout_q  <= cfg_data[TMO_W-1:0];
				REG_LIMIT:    limit_q    <= cfg_data[LIM_W-1:0];
				REG_RANGE:    range_q    <= cfg_data[RNG_W-1:0];
				REG_CENTER:   center_q   <= cfg_data[CTR_W-1:0];
				REG_SPAN:     span_q     <= cfg_data[SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	// unpack the little-endian bit stream of the frame header
	assign unp_ch[0] = {fb_q[1][2:0], fb_q[0]};
	assign unp_ch[1] = {fb_q[2][5:0], fb_q[1][7:3]};
	assign unp_ch[2] = {fb_q[4][0], fb_q[3], fb_q[2][7:6]};
	assign unp_ch[3] = {fb_q[5][3:0], fb_q[4][7:1]};
	assign unp_sw[0] = fb_q[5][5:4];
	assign unp_sw[1] = fb_q[5][7:6];

	// channel window check
	assign lo_lim = $signed({2'b00, center_q}) - $signed({3'b000, span_q});
	assign hi_lim = $signed({2'b00, center_q}) + $signed({3'b000, span_q});
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ch_ok[i] = ($signed({2'b00, unp_ch[i]}) >= lo_lim) &&
			           ($signed({2'b00, unp_ch[i]}) <= hi_lim);
		end
	end

	// byte counter, header store and frame flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			done_q     <= 1'b0;
			fvalid_q   <= 1'b0;
		end else if (cmd.accept) begin
			done_q   <= 1'b0;
			fvalid_q <= 1'b0;
			unique case (mode_t'(mode))
				MODE_BYTE: begin
					if (byte_cnt_q < CNT_W'(FRAME_BYTES)) begin
						byte_cnt_q <= byte_cnt_q + 1'b1;
					end
				end
				MODE_IDLE: begin
					byte_cnt_q <= '0;
					if (byte_cnt_q == CNT_W'(FRAME_BYTES)) begin
						done_q   <= 1'b1;
						fvalid_q <= &ch_ok;
					end
				end
				MODE_TICK, MODE_NONE: ;
			endcase
		end
	end

	// header bytes, written at the byte count position
	always_ff @(posedge clk) begin
		if (cmd.accept && mode_t'(mode) == MODE_BYTE &&
		    byte_cnt_q < CNT_W'(HDR_BYTES)) begin
			fb_q[byte_cnt_q[HDR_IDX_W-1:0]] <= rx_byte;
		end
	end

	// channels and switches, updated on every complete frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) ch_q[i] <= '0;
			for (int i = 0; i < 2; i++) sw_q[i] <= '0;
		end else if (cmd.accept && mode_t'(mode) == MODE_IDLE &&
		             byte_cnt_q == CNT_W'(FRAME_BYTES)) begin
			for (int i = 0; i < 4; i++) ch_q[i] <= unp_ch[i];
			for (int i = 0; i < 2; i++) sw_q[i] <= unp_sw[i];
		end
	end

	// age since last valid frame, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '1;
		end else if (cmd.accept) begin
			if (mode_t'(mode) == MODE_IDLE && byte_cnt_q == CNT_W'(FRAME_BYTES) &&
			    (&ch_ok)) begin
				age_q <= '0;
			end else if (mode_t'(mode) == MODE_TICK && age_q != '1) begin
				age_q <= age_q + 1'b1;
			end
		end
	end

	// stick offset from center
	assign diff     = $signed({1'b0, ch_q[1]}) - $signed({1'b0, center_q});
	assign abs_diff = diff[CTR_W] ? CH_W'(-diff) : diff[CH_W-1:0];

	// restoring divider step, one quotient bit per cycle
	assign trial    = {rem_q, work_q[PROD_W-1]};
	assign trial_ge = trial >= {1'b0, range_q};

	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			work_q <= PROD_W'(abs_diff) * PROD_W'(limit_q);
			rem_q  <= '0;
			step_q <= '0;
			neg_q  <= diff[CTR_W];
			dead_q <= abs_diff < CH_W'(deadzone_q);
			zero_q <= (abs_diff == '0) || (limit_q == '0);
		end else if (cmd.div_step) begin
			work_q <= {work_q[PROD_W-2:0], trial_ge};
			rem_q  <= trial_ge ? RNG_W'(trial - {1'b0, range_q}) : trial[RNG_W-1:0];
			step_q <= step_q + 1'b1;
		end
	end

	assign status.div_last = step_q == STEP_W'(PROD_W - 1);

	// clamp, sign and staleness
	always_comb begin
		is_fresh = age_q < timeout_q;
		if (zero_q) begin
			mag = '0;
		end else if (work_q > PROD_W'(limit_q)) begin
			mag = limit_q;
		end else begin
			mag = work_q[LIM_W-1:0];
		end
		if (!is_fresh || dead_q) begin
			cur = '0;
		end else if (neg_q) begin
			cur = -$signed({1'b0, mag});
		end else begin
			cur = $signed({1'b0, mag});
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			current_cmd <= cur;
			fresh       <= is_fresh;
			frame_done  <= done_q;
			frame_valid <= fvalid_q;
			ch_right_x  <= ch_q[0];
			ch_right_y  <= ch_q[1];
			ch_left_x   <= ch_q[2];
			ch_left_y   <= ch_q[3];
			switch_one  <= sw_q[0];
			switch_two  <= sw_q[1];
		end
	end

endmodule

// ----- rtl/rc_frame_decoder_current_command.sv -----
// top level: remote-control frame decoder with stick-to-current mapping
// Each event (received byte, line idle, millisecond tick) yields exactly one
// result transaction. An event is taken, the frame and age state update at
// acceptance, then channel 1 is mapped to a current through a multiplier and a
// restoring divider that produces one quotient bit per cycle; an event passes
// through acceptance, the multiply, the divide steps over the 26-bit product
// and the result load. The next event is taken while a finished result
// still waits at the output register. The block starts stale: current is zero
// until a valid 18-byte frame arrives. Registers are written through the
// config channel, which is always ready, and must only be written while idle.
module rc_frame_decoder_current_command import rcfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [CUR_W-1:0] current_cmd,
	output logic                  fresh,
	output logic                  frame_done,
	output logic                  frame_valid,
	output logic [CH_W-1:0]       ch_right_x,
	output logic [CH_W-1:0]       ch_right_y,
	output logic [CH_W-1:0]       ch_left_x,
	output logic [CH_W-1:0]       ch_left_y,
	output logic [SW_W-1:0]       switch_one,
	output logic [SW_W-1:0]       switch_two,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	// sequencer
	rcfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// state, mapping and result registers
	rcfd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.mode        (mode),
		.rx_byte     (rx_byte),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.current_cmd (current_cmd),
		.fresh       (fresh),
		.frame_done  (frame_done),
		.frame_valid (frame_valid),
		.ch_right_x  (ch_right_x),
		.ch_right_y  (ch_right_y),
		.ch_left_x   (ch_left_x),
		.ch_left_y   (ch_left_y),
		.switch_one  (switch_one),
		.switch_two  (switch_two)
	);

endmodule
